// ----- hdl/csim_pkg.sv -----
package csim_pkg;

    localparam int ELEM_BITS_DEF = 16;

    localparam int ACC_W      = 48;
    localparam int HALF_W     = ACC_W / 2;
    localparam int PROD_W     = 2 * ACC_W;
    localparam int ROOT_W     = ACC_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int Q_W        = 16;
    localparam int Q_FRAC     = 14;
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_W      = ROOT_W + DIV_STEPS;
    localparam int MUL_STEPS  = 4;
    localparam int MUL_SEL_W  = 2;
    localparam int SQRT_STEPS = PROD_W / 2;
    localparam int CNT_W      = 6;

    localparam logic [Q_W-2:0] Q_ONE = (Q_W-1)'(16384);

    typedef enum logic [2:0] {
        S_ACC,
        S_CHK,
        S_MUL,
        S_SQRT,
        S_DIVI,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 accept;
        logic                 load;
        logic                 mul_step;
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 sqrt_step;
        logic                 div_init;
        logic                 div_step;
        logic                 emit;
    } t_dp_cmd;

    typedef struct packed {
        logic prod_last;
        logic acc_zero;
        logic out_busy;
    } t_dp_sts;

endpackage

// ----- hdl/csim_ctrl.sv -----
module csim_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    input  csim_pkg::t_dp_sts  i_sts,
    output csim_pkg::t_dp_cmd  o_cmd
);

    csim_pkg::t_state                r_state;
    csim_pkg::t_state                n_state;
    logic [csim_pkg::CNT_W-1:0]      r_cnt;
    logic [csim_pkg::CNT_W-1:0]      n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csim_pkg::S_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            csim_pkg::S_ACC: begin
                if (i_sts.prod_last) begin
                    n_state = csim_pkg::S_CHK;
                end
            end
            csim_pkg::S_CHK: begin
                n_cnt   = '0;
                n_state = i_sts.acc_zero ? csim_pkg::S_OUT : csim_pkg::S_MUL;
            end
            csim_pkg::S_MUL: begin
                if (r_cnt == csim_pkg::CNT_W'(csim_pkg::MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = csim_pkg::S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            csim_pkg::S_SQRT: begin
                if (r_cnt == csim_pkg::CNT_W'(csim_pkg::SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = csim_pkg::S_DIVI;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            csim_pkg::S_DIVI: begin
                n_cnt   = '0;
                n_state = csim_pkg::S_DIV;
            end
            csim_pkg::S_DIV: begin
                if (r_cnt == csim_pkg::CNT_W'(csim_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = csim_pkg::S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            csim_pkg::S_OUT: begin
                if (!i_sts.out_busy) begin
                    n_state = csim_pkg::S_ACC;
                end
            end
            default: begin
                n_state = csim_pkg::S_ACC;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            csim_pkg::S_ACC: begin
                o_in_ready   = !i_sts.prod_last;
                o_cmd.accept = i_in_valid && !i_sts.prod_last;
            end
            csim_pkg::S_CHK: begin
                o_cmd.load = 1'b1;
            end
            csim_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                o_cmd.mul_sel  = r_cnt[csim_pkg::MUL_SEL_W-1:0];
            end
            csim_pkg::S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
            end
            csim_pkg::S_DIVI: begin
                o_cmd.div_init = 1'b1;
            end
            csim_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            csim_pkg::S_OUT: begin
                o_cmd.emit = !i_sts.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // After the final pair of a vector no further pair may enter until the score is out.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> !o_in_ready)
        else $error("input accepted right after a last transaction");

    a_chk_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csim_pkg::S_CHK) |-> ($past(r_state) == csim_pkg::S_ACC))
        else $error("check state entered from outside accumulation");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.load, o_cmd.mul_step, o_cmd.sqrt_step,
                  o_cmd.div_init, o_cmd.div_step, o_cmd.emit}))
        else $error("more than one datapath command at once");

endmodule

// ----- hdl/csim_dp.sv -----
module csim_dp #(
    parameter int ELEM_BITS = csim_pkg::ELEM_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic signed [ELEM_BITS-1:0]      i_elem_a,
    input  logic signed [ELEM_BITS-1:0]      i_elem_b,
    input  logic                             i_last,
    input  csim_pkg::t_dp_cmd                i_cmd,
    output csim_pkg::t_dp_sts                o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [csim_pkg::Q_W-1:0]  o_similarity,
    output logic                             o_zero_norm
);

    localparam int ACC_W = csim_pkg::ACC_W;
    localparam int PRD_W = 2 * ELEM_BITS;
    localparam int SUM_W = ((PRD_W > ACC_W) ? PRD_W : ACC_W) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

    function automatic logic signed [ACC_W-1:0] f_sat(input logic signed [SUM_W-1:0] s);
        logic signed [ACC_W-1:0] res;
        if (s > SAT_HI) begin
            res = SAT_HI[ACC_W-1:0];
        end else if (s < SAT_LO) begin
            res = SAT_LO[ACC_W-1:0];
        end else begin
            res = s[ACC_W-1:0];
        end
        return res;
    endfunction

    logic                                 r_p_vld;
    logic                                 r_p_last;
    logic signed [PRD_W-1:0]              r_p_ab;
    logic signed [PRD_W-1:0]              r_p_aa;
    logic signed [PRD_W-1:0]              r_p_bb;

    logic signed [ACC_W-1:0]              r_acc_ab;
    logic signed [ACC_W-1:0]              r_acc_aa;
    logic signed [ACC_W-1:0]              r_acc_bb;
    logic signed [ACC_W-1:0]              n_acc_ab;
    logic signed [ACC_W-1:0]              n_acc_aa;
    logic signed [ACC_W-1:0]              n_acc_bb;

    logic                                 r_zero;
    logic                                 r_neg;
    logic [ACC_W-1:0]                     r_mag;
    logic [ACC_W-1:0]                     r_x;
    logic [ACC_W-1:0]                     r_y;

    logic [csim_pkg::PROD_W-1:0]          r_prod;
    logic [csim_pkg::HALF_W-1:0]          n_xh;
    logic [csim_pkg::HALF_W-1:0]          n_yh;
    logic [2*csim_pkg::HALF_W-1:0]        n_pp;
    logic [csim_pkg::PROD_W-1:0]          n_add;

    logic [csim_pkg::REM_W-1:0]           r_rem;
    logic [csim_pkg::ROOT_W-1:0]          r_root;
    logic [csim_pkg::REM_W-1:0]           n_rem_sh;
    logic [csim_pkg::REM_W-1:0]           n_trial;
    logic                                 n_sq_ge;

    logic [csim_pkg::DIV_W-1:0]           r_drem;
    logic [csim_pkg::DIV_W-1:0]           r_dsor;
    logic [csim_pkg::Q_W-1:0]             r_q;
    logic                                 n_div_ge;

    logic                                 n_clamp;
    logic [csim_pkg::Q_W-2:0]             n_qmag;
    logic signed [csim_pkg::Q_W-1:0]      n_sim;

    logic                                 r_out_vld;
    logic signed [csim_pkg::Q_W-1:0]      r_out_sim;
    logic                                 r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_p_last <= 1'b0;
        end else begin
            r_p_vld  <= i_cmd.accept;
            r_p_last <= i_cmd.accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_ab <= i_elem_a * i_elem_b;
            r_p_aa <= i_elem_a * i_elem_a;
            r_p_bb <= i_elem_b * i_elem_b;
        end
    end

    always_comb begin
        n_acc_ab = f_sat(SUM_W'(r_acc_ab) + SUM_W'(r_p_ab));
        n_acc_aa = f_sat(SUM_W'(r_acc_aa) + SUM_W'(r_p_aa));
        n_acc_bb = f_sat(SUM_W'(r_acc_bb) + SUM_W'(r_p_bb));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_ab <= '0;
            r_acc_aa <= '0;
            r_acc_bb <= '0;
        end else if (i_cmd.load) begin
            r_acc_ab <= '0;
            r_acc_aa <= '0;
            r_acc_bb <= '0;
        end else if (r_p_vld) begin
            r_acc_ab <= n_acc_ab;
            r_acc_aa <= n_acc_aa;
            r_acc_bb <= n_acc_bb;
        end
    end

    always_comb begin
        n_xh = i_cmd.mul_sel[1] ? r_x[ACC_W-1:csim_pkg::HALF_W] : r_x[csim_pkg::HALF_W-1:0];
        n_yh = i_cmd.mul_sel[0] ? r_y[ACC_W-1:csim_pkg::HALF_W] : r_y[csim_pkg::HALF_W-1:0];
        n_pp = n_xh * n_yh;
        case (i_cmd.mul_sel)
            2'd1, 2'd2: n_add = csim_pkg::PROD_W'(n_pp) << csim_pkg::HALF_W;
            2'd3:       n_add = csim_pkg::PROD_W'(n_pp) << (2 * csim_pkg::HALF_W);
            default:    n_add = csim_pkg::PROD_W'(n_pp);
        endcase
    end

    always_comb begin
        n_rem_sh = {r_rem[csim_pkg::REM_W-3:0], r_prod[csim_pkg::PROD_W-1 -: 2]};
        n_trial  = {r_root, 2'b01};
        n_sq_ge  = (n_rem_sh >= n_trial);
        n_div_ge = (r_drem >= r_dsor);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= (r_acc_aa == '0) || (r_acc_bb == '0);
            r_neg  <= r_acc_ab[ACC_W-1];
            r_mag  <= r_acc_ab[ACC_W-1] ? -r_acc_ab : r_acc_ab;
            r_x    <= r_acc_aa;
            r_y    <= r_acc_bb;
            r_prod <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.mul_step) begin
            r_prod <= r_prod + n_add;
        end else if (i_cmd.sqrt_step) begin
            r_prod <= r_prod << 2;
            r_rem  <= n_sq_ge ? (n_rem_sh - n_trial) : n_rem_sh;
            r_root <= {r_root[csim_pkg::ROOT_W-2:0], n_sq_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_drem <= csim_pkg::DIV_W'({r_mag, {csim_pkg::Q_FRAC{1'b0}}})
                    + csim_pkg::DIV_W'(r_root >> 1);
            r_dsor <= csim_pkg::DIV_W'({r_root, {(csim_pkg::DIV_STEPS-1){1'b0}}});
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            r_drem <= n_div_ge ? (r_drem - r_dsor) : r_drem;
            r_dsor <= r_dsor >> 1;
            r_q    <= {r_q[csim_pkg::Q_W-2:0], n_div_ge};
        end
    end

    always_comb begin
        n_clamp = r_q[csim_pkg::Q_W-1] || (r_q[csim_pkg::Q_W-2:0] > csim_pkg::Q_ONE);
        n_qmag  = n_clamp ? csim_pkg::Q_ONE : r_q[csim_pkg::Q_W-2:0];
        if (r_zero) begin
            n_sim = '0;
        end else if (r_neg) begin
            n_sim = -{1'b0, n_qmag};
        end else begin
            n_sim = {1'b0, n_qmag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sim  <= n_sim;
            r_out_zero <= r_zero;
        end
    end

    always_comb begin
        o_sts.prod_last = r_p_vld && r_p_last;
        o_sts.acc_zero  = (r_acc_aa == '0) || (r_acc_bb == '0);
        o_sts.out_busy  = r_out_vld && !i_out_ready;
    end

    assign o_out_valid  = r_out_vld;
    assign o_similarity = r_out_sim;
    assign o_zero_norm  = r_out_zero;

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out_sim <= $signed({1'b0, csim_pkg::Q_ONE}))
                    && (r_out_sim >= -$signed({1'b0, csim_pkg::Q_ONE}))))
        else $error("similarity outside minus one to one");

    a_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_zero) |-> (r_out_sim == '0))
        else $error("zero norm result with nonzero similarity");

    a_squares_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_acc_aa[ACC_W-1] && !r_acc_bb[ACC_W-1])
        else $error("square sum went negative");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> ((r_acc_ab == '0) && (r_acc_aa == '0) && (r_acc_bb == '0)))
        else $error("sums not cleared after a vector");

endmodule

// ----- hdl/cosine_similarity_score_top.sv -----
// Cosine similarity scorer. Element pairs of two Q8.8 vectors enter one per cycle and
// build the cross sum and both square sums in saturating 48-bit accumulators. The pair
// marked with tlast ends the vector: the input then stalls while the 96-bit norm
// product is formed from half-width partial products, its square root is found one bit
// per cycle and the ratio is divided out one quotient bit per cycle, until the score
// has been handed on; a vector with zero norm skips the product, root and division.
// The score is a signed Q1.14 value whose magnitude is rounded half up and clamped to
// plus or minus one; zero norm gives 0 with the flag set.
module cosine_similarity_score_top #(
    parameter int ELEM_BITS = csim_pkg::ELEM_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: elem_a, elem_b, zero fill to a whole byte.
    input  logic [((2*ELEM_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: similarity.
    output logic [csim_pkg::Q_W-1:0]             m_axis_tdata,
    // Fields from bit 0: zero_norm.
    output logic                                 m_axis_tuser
);

    csim_pkg::t_dp_cmd                  w_cmd;
    csim_pkg::t_dp_sts                  w_sts;
    logic signed [csim_pkg::Q_W-1:0]    w_sim;

    csim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    csim_dp #(
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_a     ($signed(s_axis_tdata[ELEM_BITS-1:0])),
        .i_elem_b     ($signed(s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS])),
        .i_last       (s_axis_tlast),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_similarity (w_sim),
        .o_zero_norm  (m_axis_tuser)
    );

    assign m_axis_tdata = w_sim;

endmodule
